@@ hw/rtl/ialu_pkg.sv @@
// ----------------------------------------------------------------------------
// ialu_pkg
// shared types and constants of the integer alu
// ----------------------------------------------------------------------------
package ialu_pkg;

   localparam int DataWidth = 32;
   localparam int FuncWidth = 3;

   typedef enum logic [FuncWidth-1:0] {
      FUNC_ADD = 3'd0,
      FUNC_SUB = 3'd1,
      FUNC_MUL = 3'd2,
      FUNC_DIV = 3'd3,
      FUNC_MOD = 3'd4
   } func_type;

   typedef struct packed {
      logic sign_q;
      logic sign_r;
      logic zero;
   } ctrl_type;

endpackage

@@ hw/rtl/ialu_if.sv @@
// ----------------------------------------------------------------------------
// ialu_req_if / ialu_rsp_if
// valid/ready channels of the integer alu
// ----------------------------------------------------------------------------
interface ialu_req_if #(parameter int DATA_WIDTH = ialu_pkg::DataWidth);
   logic                           valid;
   logic                           ready;
   logic [ialu_pkg::FuncWidth-1:0] func;
   logic signed [DATA_WIDTH-1:0]   operand_a;
   logic signed [DATA_WIDTH-1:0]   operand_b;
   modport source (output valid, func, operand_a, operand_b, input ready);
   modport sink (input valid, func, operand_a, operand_b, output ready);
endinterface

interface ialu_rsp_if #(parameter int DATA_WIDTH = ialu_pkg::DataWidth);
   logic                         valid;
   logic                         ready;
   logic signed [DATA_WIDTH-1:0] result;
   modport source (output valid, result, input ready);
   modport sink (input valid, result, output ready);
endinterface

@@ hw/rtl/ialu_div_stage.sv @@
// ----------------------------------------------------------------------------
// ialu_div_stage
// one restoring division step, registered, with stall
// ----------------------------------------------------------------------------
module ialu_div_stage #(
   parameter int DATA_WIDTH = ialu_pkg::DataWidth
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           advance,
   input  logic                           valid_in,
   input  logic [ialu_pkg::FuncWidth-1:0] func_in,
   input  logic [DATA_WIDTH-1:0]          data_in,
   input  ialu_pkg::ctrl_type             ctrl_in,
   input  logic [DATA_WIDTH-1:0]          quot_in,
   input  logic [DATA_WIDTH-1:0]          rem_in,
   input  logic [DATA_WIDTH-1:0]          div_in,
   output logic                           valid_out,
   output logic [ialu_pkg::FuncWidth-1:0] func_out,
   output logic [DATA_WIDTH-1:0]          data_out,
   output ialu_pkg::ctrl_type             ctrl_out,
   output logic [DATA_WIDTH-1:0]          quot_out,
   output logic [DATA_WIDTH-1:0]          rem_out,
   output logic [DATA_WIDTH-1:0]          div_out
);
   logic                           valid_ff;
   logic [ialu_pkg::FuncWidth-1:0] func_ff;
   logic [DATA_WIDTH-1:0]          data_ff, quot_ff, rem_ff, div_ff;
   logic [DATA_WIDTH-1:0]          quot_in_n, rem_in_n;
   ialu_pkg::ctrl_type             ctrl_ff;
   logic [DATA_WIDTH:0]            shifted, diff;

   always_comb begin
      shifted = {rem_in, quot_in[DATA_WIDTH-1]};
      diff    = shifted - {1'b0, div_in};
      if (!diff[DATA_WIDTH]) begin
         rem_in_n  = diff[DATA_WIDTH-1:0];
         quot_in_n = {quot_in[DATA_WIDTH-2:0], 1'b1};
      end else begin
         rem_in_n  = shifted[DATA_WIDTH-1:0];
         quot_in_n = {quot_in[DATA_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
      if (advance) begin
         func_ff <= func_in;
         data_ff <= data_in;
         ctrl_ff <= ctrl_in;
         quot_ff <= quot_in_n;
         rem_ff  <= rem_in_n;
         div_ff  <= div_in;
      end
   end

   assign valid_out = valid_ff;
   assign func_out  = func_ff;
   assign data_out  = data_ff;
   assign ctrl_out  = ctrl_ff;
   assign quot_out  = quot_ff;
   assign rem_out   = rem_ff;
   assign div_out   = div_ff;
endmodule

@@ hw/rtl/integer_alu_add_sub_mul_div_mod_unit.sv @@
// pipeline: stage 0, then one register stage per quotient bit, then the output stage
// throughput: one transaction per cycle; a stalled output freezes the whole pipeline
// reset: clears all stage valid bits; payload registers are not reset
// ----------------------------------------------------------------------------
// integer_alu_add_sub_mul_div_mod_unit
// pipelined signed alu: add, subtract, multiply, divide, modulus
// ----------------------------------------------------------------------------
module integer_alu_add_sub_mul_div_mod_unit #(
   parameter int DATA_WIDTH = ialu_pkg::DataWidth
) (
   input logic clock,
   input logic reset,
   ialu_req_if.sink   req,
   ialu_rsp_if.source rsp
);
   localparam int Steps = DATA_WIDTH;

   logic advance;
   // output stage holds; pipeline moves when output empty or taken
   assign advance   = !rsp.valid || rsp.ready;
   assign req.ready = advance;

   // stage 0: magnitudes, signs, add/sub/mul
   logic                           s0_valid_ff;
   logic [ialu_pkg::FuncWidth-1:0] s0_func_ff;
   logic [DATA_WIDTH-1:0]          s0_data_ff, s0_ua_ff, s0_ub_ff;
   ialu_pkg::ctrl_type             s0_ctrl_ff;
   logic [DATA_WIDTH-1:0]          a_u, b_u, data_in;
   logic                           neg_a, neg_b;

   assign a_u   = req.operand_a;
   assign b_u   = req.operand_b;
   assign neg_a = a_u[DATA_WIDTH-1];
   assign neg_b = b_u[DATA_WIDTH-1];

   always_comb begin
      case (req.func)
         ialu_pkg::FUNC_ADD: data_in = a_u + b_u;
         ialu_pkg::FUNC_SUB: data_in = a_u - b_u;
         ialu_pkg::FUNC_MUL: data_in = DATA_WIDTH'(a_u * b_u);
         default:            data_in = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff <= req.valid;
      end
      if (advance) begin
         s0_func_ff         <= req.func;
         s0_data_ff         <= data_in;
         s0_ua_ff           <= neg_a ? -a_u : a_u;
         s0_ub_ff           <= neg_b ? -b_u : b_u;
         s0_ctrl_ff.sign_q  <= neg_a ^ neg_b;
         s0_ctrl_ff.sign_r  <= neg_a;
         s0_ctrl_ff.zero    <= (b_u == '0);
      end
   end

   // division stages
   logic                           st_valid [Steps+1];
   logic [ialu_pkg::FuncWidth-1:0] st_func  [Steps+1];
   logic [DATA_WIDTH-1:0]          st_data  [Steps+1];
   ialu_pkg::ctrl_type             st_ctrl  [Steps+1];
   logic [DATA_WIDTH-1:0]          st_quot  [Steps+1];
   logic [DATA_WIDTH-1:0]          st_rem   [Steps+1];
   logic [DATA_WIDTH-1:0]          st_div   [Steps+1];

   assign st_valid[0] = s0_valid_ff;
   assign st_func[0]  = s0_func_ff;
   assign st_data[0]  = s0_data_ff;
   assign st_ctrl[0]  = s0_ctrl_ff;
   assign st_quot[0]  = s0_ua_ff;
   assign st_rem[0]   = '0;
   assign st_div[0]   = s0_ub_ff;

   for (genvar i = 0; i < Steps; i++) begin : g_div
      ialu_div_stage #(.DATA_WIDTH(DATA_WIDTH)) u_stage (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .valid_in  (st_valid[i]),
         .func_in   (st_func[i]),
         .data_in   (st_data[i]),
         .ctrl_in   (st_ctrl[i]),
         .quot_in   (st_quot[i]),
         .rem_in    (st_rem[i]),
         .div_in    (st_div[i]),
         .valid_out (st_valid[i+1]),
         .func_out  (st_func[i+1]),
         .data_out  (st_data[i+1]),
         .ctrl_out  (st_ctrl[i+1]),
         .quot_out  (st_quot[i+1]),
         .rem_out   (st_rem[i+1]),
         .div_out   (st_div[i+1])
      );
   end

   // output stage: sign fixup and selection
   logic                  out_valid_ff;
   logic [DATA_WIDTH-1:0] out_result_ff, result_in, q_fin, r_fin;
   ialu_pkg::ctrl_type    c_fin;

   assign c_fin = st_ctrl[Steps];
   assign q_fin = st_quot[Steps];
   assign r_fin = st_rem[Steps];

   always_comb begin
      case (st_func[Steps])
         ialu_pkg::FUNC_DIV: result_in = c_fin.zero ? '0 : (c_fin.sign_q ? -q_fin : q_fin);
         ialu_pkg::FUNC_MOD: result_in = c_fin.zero ? '0 : (c_fin.sign_r ? -r_fin : r_fin);
         default:            result_in = st_data[Steps];
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= st_valid[Steps];
      end
      if (advance) begin
         out_result_ff <= result_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.result = out_result_ff;
endmodule

@@ sim/integer_alu_add_sub_mul_div_mod_unit_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// integer_alu_add_sub_mul_div_mod_unit_tb
// drives directed and random alu transactions through the pipelined unit with
// random idling on both sides, predicts each result and compares it in order
// ----------------------------------------------------------------------------
module integer_alu_add_sub_mul_div_mod_unit_tb;

   localparam int W = ialu_pkg::DataWidth;
   localparam int FW = ialu_pkg::FuncWidth;
   localparam logic [W-1:0] MinVal = {1'b1, {(W-1){1'b0}}};
   localparam logic [W-1:0] MaxVal = {1'b0, {(W-1){1'b1}}};
   localparam logic [W-1:0] AllOnes = {W{1'b1}};
   localparam int NumRandom = 1030;
   localparam int Latency = W + 2;
   // codes with no operation behind them
   localparam logic [FW-1:0] FuncBadLo = 3'd5;
   localparam logic [FW-1:0] FuncBadMid = 3'd6;
   localparam logic [FW-1:0] FuncBadHi = 3'd7;

   typedef struct {
      logic [FW-1:0] func;
      logic [W-1:0]  a;
      logic [W-1:0]  b;
      bit            fixed;
      logic [W-1:0]  want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic hold_rsp = 1'b0;
   logic quiet = 1'b0;
   int   errors = 0;
   bit   done = 1'b0;
   logic [W-1:0] results_due[$];
   stim_row_type rows[$];

   ialu_req_if #(.DATA_WIDTH(W)) req ();
   ialu_rsp_if #(.DATA_WIDTH(W)) rsp ();

   integer_alu_add_sub_mul_div_mod_unit #(.DATA_WIDTH(W)) DUT (
      .clock(clock),
      .reset(reset),
      .req  (req.sink),
      .rsp  (rsp.source)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [W-1:0] alu_result(logic [FW-1:0] f, logic [W-1:0] a,
                                               logic [W-1:0] b);
      logic [W-1:0] ma, mb, r;
      ma = a[W-1] ? -a : a;
      mb = b[W-1] ? -b : b;
      case (f)
         ialu_pkg::FUNC_ADD: r = a + b;
         ialu_pkg::FUNC_SUB: r = a - b;
         ialu_pkg::FUNC_MUL: r = a * b;
         ialu_pkg::FUNC_DIV: begin
            if (b == '0) r = '0;
            else begin
               r = ma / mb;
               if (a[W-1] != b[W-1]) r = -r;
            end
         end
         ialu_pkg::FUNC_MOD: begin
            if (b == '0) r = '0;
            else begin
               r = ma % mb;
               if (a[W-1]) r = -r;
            end
         end
         default: r = '0;
      endcase
      return r;
   endfunction

   task automatic report(string what, logic [W-1:0] got, logic [W-1:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      errors++;
   endtask

   function automatic logic [W-1:0] rand_operand();
      logic [W-1:0] v;
      case ($urandom_range(0, 7))
         0: v = MinVal;
         1: v = MaxVal;
         2: v = AllOnes;
         3: v = '0;
         4: v = W'($urandom_range(0, 20)) - W'(10);
         default: v = W'({$urandom, $urandom});
      endcase
      return v;
   endfunction

   function automatic stim_row_type mk(logic [FW-1:0] f, logic [W-1:0] a, logic [W-1:0] b,
                                       bit fixed = 1'b0, logic [W-1:0] want = '0);
      stim_row_type r;
      r.func = f; r.a = a; r.b = b; r.fixed = fixed; r.want = want;
      return r;
   endfunction

   task automatic send(stim_row_type r);
      req.func <= r.func;
      req.operand_a <= r.a;
      req.operand_b <= r.b;
      req.valid <= 1'b1;
      do @(posedge clock); while (!req.ready);
      results_due.push_back(r.fixed ? r.want : alu_result(r.func, r.a, r.b));
      @(negedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
   endtask

   // result side
   initial begin
      rsp.ready = 1'b0;
      @(negedge clock);
      while (!done) begin
         if (hold_rsp) begin
            // long hold-off so the pipeline fills and stalls the input
            rsp.ready <= 1'b0;
            repeat (3 * Latency) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp.ready <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clock);
         end else begin
            rsp.ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (results_due.size() == 0) begin
            report("unexpected transaction", rsp.result, '0);
         end else begin
            logic [W-1:0] want;
            want = results_due.pop_front();
            if (rsp.result !== want) report("result", rsp.result, want);
         end
      end
   end

   initial begin
      req.valid = 1'b0;
      req.func = '0;
      req.operand_a = '0;
      req.operand_b = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      rows.push_back(mk(ialu_pkg::FUNC_ADD, MaxVal, W'(1), 1'b1, MinVal));
      rows.push_back(mk(ialu_pkg::FUNC_ADD, MinVal, AllOnes, 1'b1, MaxVal));
      rows.push_back(mk(ialu_pkg::FUNC_ADD, AllOnes, AllOnes, 1'b1, AllOnes - W'(1)));
      rows.push_back(mk(ialu_pkg::FUNC_SUB, MinVal, W'(1), 1'b1, MaxVal));
      rows.push_back(mk(ialu_pkg::FUNC_SUB, '0, MinVal, 1'b1, MinVal));
      rows.push_back(mk(ialu_pkg::FUNC_SUB, W'(5), W'(7)));
      rows.push_back(mk(ialu_pkg::FUNC_MUL, MinVal, AllOnes, 1'b1, MinVal));
      rows.push_back(mk(ialu_pkg::FUNC_MUL, MaxVal, MaxVal, 1'b1, W'(1)));
      rows.push_back(mk(ialu_pkg::FUNC_MUL, W'(-7), W'(6)));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, W'(100), '0, 1'b1, '0));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, MinVal, AllOnes, 1'b1, MinVal));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, W'(-7), W'(2), 1'b1, W'(-3)));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, W'(7), W'(-2), 1'b1, W'(-3)));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, MinVal, MinVal, 1'b1, W'(1)));
      rows.push_back(mk(ialu_pkg::FUNC_DIV, MaxVal, MinVal, 1'b1, '0));
      rows.push_back(mk(ialu_pkg::FUNC_MOD, W'(100), '0, 1'b1, '0));
      rows.push_back(mk(ialu_pkg::FUNC_MOD, MinVal, AllOnes, 1'b1, '0));
      rows.push_back(mk(ialu_pkg::FUNC_MOD, W'(-7), W'(2), 1'b1, W'(-1)));
      rows.push_back(mk(ialu_pkg::FUNC_MOD, W'(7), W'(-2), 1'b1, W'(1)));
      rows.push_back(mk(ialu_pkg::FUNC_MOD, MinVal, MaxVal));
      rows.push_back(mk(FuncBadLo, MaxVal, MaxVal, 1'b1, '0));
      rows.push_back(mk(FuncBadMid, AllOnes, AllOnes, 1'b1, '0));
      rows.push_back(mk(FuncBadHi, MinVal, W'(3), 1'b1, '0));
      foreach (rows[i]) send(rows[i]);

      // sender waits until the pipeline has drained
      req.valid <= 1'b0;
      wait (results_due.size() == 0);
      @(negedge clock);

      for (int n = 0; n < NumRandom; n++) begin
         logic [FW-1:0] f;
         if (n == 200) hold_rsp = 1'b1;
         if (n == NumRandom - 150) quiet = 1'b1;
         f = ($urandom_range(0, 9) == 0)
             ? FW'($urandom_range(FuncBadLo, FuncBadHi))
             : FW'($urandom_range(ialu_pkg::FUNC_ADD, ialu_pkg::FUNC_MOD));
         send(mk(f, rand_operand(), rand_operand()));
      end
      req.valid <= 1'b0;
      wait (results_due.size() == 0);
      repeat (Latency + 10) @(posedge clock);
      done = 1'b1;
      if (errors == 0) $display("integer_alu_add_sub_mul_div_mod_unit_tb OK");
      else $display("integer_alu_add_sub_mul_div_mod_unit_tb NOT OK");
      $finish;
   end

   initial begin
      #2ms;
      $display("timeout");
      $display("integer_alu_add_sub_mul_div_mod_unit_tb NOT OK");
      $finish;
   end

endmodule

@@ filelist.f @@
hw/rtl/ialu_pkg.sv
hw/rtl/ialu_if.sv
hw/rtl/ialu_div_stage.sv
hw/rtl/integer_alu_add_sub_mul_div_mod_unit.sv
sim/integer_alu_add_sub_mul_div_mod_unit_tb.sv
